// ===== rtl/n_queens_conflict_scorer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the N-queens conflict scorer
// Shared property wrappers; the clock and reset names are those of the RTL.
// ----------------------------------------------------------------------------
`ifndef N_QUEENS_CONFLICT_SCORER_ASSERT_SVH
`define N_QUEENS_CONFLICT_SCORER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NQCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NQCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/nqcs_pkg.sv =====
// ----------------------------------------------------------------------------
// nqcs_pkg
// Constants, payload types and fitness tables of the N-queens conflict scorer.
// ----------------------------------------------------------------------------
package nqcs_pkg;

   localparam int MAX_QUEENS = 64;
   localparam int COL_W      = 6;
   localparam int PAIR_W     = 11;
   localparam int FIT_W      = 16;
   localparam int ROW_W      = $clog2(MAX_QUEENS + 1);
   localparam int ADDR_W     = $clog2(MAX_QUEENS);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

   // Divide by ten: q = (p * 6554) >> 16, exact for every 11-bit p.
   localparam int DIV10_MUL_W = 13;
   localparam int DIV10_SHIFT = 16;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 13'd6554;
   localparam int PROD_W = PAIR_W + DIV10_MUL_W;
   localparam int QUOT_W = 8;
   localparam int REM_W  = 4;
   localparam logic [QUOT_W-1:0] QUOT_LIMIT = 8'd17;

   // Fitness datapath: base value up to 65536 plus a rounding half.
   localparam int FRAC_W = FIT_W + 1;
   localparam int FEXT_W = FIT_W + 2;
   localparam logic [FEXT_W-1:0] FIT_SAT = {2'b00, {FIT_W{1'b1}}};

   typedef struct packed {
      logic [COL_W-1:0] queen_column;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [PAIR_W-1:0] attack_pairs;
      logic [FIT_W-1:0]  fitness;
      logic              too_many_rows;
   } rsp_type;

   // A classified row on its way from the front to the back.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
      logic             ovf;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIT  = 4'b1000
   } back_state_type;

   // floor(2^(-r/10) * 65536) for remainder r.
   function automatic logic [FRAC_W-1:0] frac_base(input logic [REM_W-1:0] r);
      logic [FRAC_W-1:0] v;
      unique case (r)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd61147;
         4'd2:    v = 17'd57052;
         4'd3:    v = 17'd53231;
         4'd4:    v = 17'd49667;
         4'd5:    v = 17'd46340;
         4'd6:    v = 17'd43237;
         4'd7:    v = 17'd40342;
         4'd8:    v = 17'd37640;
         4'd9:    v = 17'd35119;
         default: v = '0;
      endcase
      return v;
   endfunction

   // 2^(-r/10) * 65536 rounded to nearest, used when the quotient is zero.
   function automatic logic [FRAC_W-1:0] frac_round(input logic [REM_W-1:0] r);
      logic [FRAC_W-1:0] v;
      unique case (r)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd61147;
         4'd2:    v = 17'd57052;
         4'd3:    v = 17'd53232;
         4'd4:    v = 17'd49667;
         4'd5:    v = 17'd46341;
         4'd6:    v = 17'd43238;
         4'd7:    v = 17'd40342;
         4'd8:    v = 17'd37641;
         4'd9:    v = 17'd35120;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/nqcs_ram.sv =====
// ----------------------------------------------------------------------------
// nqcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nqcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nqcs_fifo.sv =====
// ----------------------------------------------------------------------------
// nqcs_fifo
// Short register queue of classified rows between front and back.
// ----------------------------------------------------------------------------
module nqcs_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  nqcs_pkg::job_type         push_data,
   input  logic                      pop,
   output nqcs_pkg::job_type         head,
   output nqcs_pkg::queue_status_type status
);
   import nqcs_pkg::*;

   job_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/nqcs_front.sv =====
// ----------------------------------------------------------------------------
// nqcs_front
// Accepts rows, numbers them within the board and marks rows past capacity.
// ----------------------------------------------------------------------------
module nqcs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  nqcs_pkg::req_type          req_data,
   output logic                       req_full,
   input  nqcs_pkg::queue_status_type queue_status,
   output logic                       queue_push,
   output nqcs_pkg::job_type          queue_data
);
   import nqcs_pkg::*;

   logic [ROW_W-1:0] rows_ff, rows_in;
   logic             accept;
   logic             store_full;

   assign req_full   = queue_status.full;
   assign accept     = req_push && !queue_status.full;
   assign store_full = (rows_ff == ROW_W'(MAX_QUEENS));

   assign queue_push      = accept;
   assign queue_data.col  = req_data.queen_column;
   assign queue_data.row  = rows_ff;
   assign queue_data.last = req_data.last_row;
   assign queue_data.ovf  = store_full;

   always_comb begin
      rows_in = rows_ff;
      if (accept) begin
         if (req_data.last_row) begin
            rows_in = '0;
         end else if (!store_full) begin
            rows_in = rows_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
   end

endmodule

// ===== rtl/nqcs_back.sv =====
// ----------------------------------------------------------------------------
// nqcs_back
// Stores columns, scans earlier rows for attacks, scores the finished board.
// ----------------------------------------------------------------------------
`include "n_queens_conflict_scorer_assert.svh"

module nqcs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  nqcs_pkg::queue_status_type queue_status,
   input  nqcs_pkg::job_type          queue_head,
   output logic                       queue_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output nqcs_pkg::rsp_type          rsp_data
);
   import nqcs_pkg::*;

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [ROW_W-1:0]  issue_ff, issue_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [ROW_W-1:0]  cmp_dist_ff, cmp_dist_in;
   logic [PAIR_W-1:0] pair_ff, pair_in;
   logic              ovf_ff, ovf_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic              ram_we;
   logic [COL_W-1:0]  ram_rdata;
   logic              issue_go, scan_done, hit, rsp_load;
   logic [COL_W-1:0]  col_diff;
   logic [PROD_W-1:0] quot_prod;
   logic [PAIR_W-1:0] rem_full;
   logic [REM_W-1:0]  rem;
   logic [FEXT_W-1:0] fit_raw;
   logic [FIT_W-1:0]  fit_sat;

   nqcs_ram #(
      .WIDTH (COL_W),
      .DEPTH (MAX_QUEENS)
   ) u_column_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (queue_head.row[ADDR_W-1:0]),
      .wr_data (queue_head.col),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Scan: issue one read per earlier row, compare it in the next cycle.
   assign issue_go  = (state_ff == ST_SCAN) && (issue_ff < job_ff.row);
   assign scan_done = (state_ff == ST_SCAN) && !issue_go && !cmp_vld_ff;
   assign col_diff  = (ram_rdata > job_ff.col) ? ram_rdata - job_ff.col
                                               : job_ff.col - ram_rdata;
   assign hit = cmp_vld_ff &&
                ((col_diff == '0) ||
                 ({{ROW_W{1'b0}}, col_diff} == {{COL_W{1'b0}}, cmp_dist_ff}));

   // Scoring: p = 10q + r, then a table value shifted down by q with rounding.
   assign quot_prod = PROD_W'(pair_ff) * PROD_W'(DIV10_MUL);
   assign rem_full  = pair_ff - PAIR_W'(quot_ff) * PAIR_W'(10);
   assign rem       = rem_full[REM_W-1:0];

   always_comb begin
      if (quot_ff > QUOT_LIMIT) begin
         fit_raw = '0;
      end else if (quot_ff == '0) begin
         fit_raw = FEXT_W'(frac_round(rem));
      end else begin
         fit_raw = (FEXT_W'(frac_base(rem)) + (FEXT_W'(1) << (quot_ff - 1'b1))) >> quot_ff;
      end
      fit_sat = (fit_raw > FIT_SAT) ? FIT_SAT[FIT_W-1:0] : fit_raw[FIT_W-1:0];
   end

   assign rsp_load  = (state_ff == ST_FIT) && (!rsp_vld_ff || rsp_pop);
   assign queue_pop = (state_ff == ST_IDLE) && !queue_status.empty;
   assign ram_we    = queue_pop && !queue_head.ovf;

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = issue_go;
      cmp_dist_in = job_ff.row - issue_ff;
      pair_in     = pair_ff;
      ovf_in      = ovf_ff;
      quot_in     = quot_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_pop;

      if (hit) begin
         pair_in = (pair_ff == PAIR_MAX) ? PAIR_MAX : pair_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (queue_pop) begin
               job_in   = queue_head;
               issue_in = '0;
               if (queue_head.ovf) begin
                  ovf_in   = 1'b1;
                  state_in = queue_head.last ? ST_DIV : ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_go) begin
               issue_in = issue_ff + 1'b1;
            end
            if (scan_done) begin
               state_in = job_ff.last ? ST_DIV : ST_IDLE;
            end
         end
         ST_DIV: begin
            quot_in  = quot_prod[DIV10_SHIFT +: QUOT_W];
            state_in = ST_FIT;
         end
         ST_FIT: begin
            if (rsp_load) begin
               rsp_in.attack_pairs  = pair_ff;
               rsp_in.fitness       = fit_sat;
               rsp_in.too_many_rows = ovf_ff;
               rsp_vld_in           = 1'b1;
               pair_in              = '0;
               ovf_in               = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         pair_ff    <= '0;
         ovf_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         pair_ff    <= pair_in;
         ovf_ff     <= ovf_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      issue_ff    <= issue_in;
      cmp_dist_ff <= cmp_dist_in;
      quot_ff     <= quot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_empty = !rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `NQCS_ASSERT_NOW(a_scan_bound, state_ff == ST_SCAN, issue_ff <= job_ff.row, "scan index past row")
   `NQCS_ASSERT_NOW(a_store_in_range, ram_we, queue_head.row < ROW_W'(MAX_QUEENS), "store write past capacity")
   `NQCS_ASSERT_NEXT(a_fit_holds, state_ff == ST_FIT && rsp_vld_ff && !rsp_pop, state_ff == ST_FIT, "score dropped while output busy")
   `NQCS_ASSERT_NOW(a_no_cmp_outside_scan, cmp_vld_ff, state_ff == ST_SCAN, "compare pending outside scan")

endmodule

// ===== rtl/n_queens_conflict_scorer.sv =====
// ----------------------------------------------------------------------------
// n_queens_conflict_scorer
// Counts attacking queen pairs of a board sent row by row and scores it.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload      Moves
//  -------  --------------------  -----------  ---------------------------------
//  req      req_push / req_full   req_data     one board row per request
//  rsp      rsp_pop / rsp_empty   rsp_data     pair count, fitness, overflow flag
//
//  A row at index k passes through the scan engine in steps: a pop that
//  stores its column, one read per earlier row on the single read port, a
//  drain of the last compare if any, and a close of the scan. A last row
//  adds the divide-by-ten and fitness shift steps; rows past capacity skip
//  the store and scan. A four-entry queue lets requests arrive while a scan
//  runs. Reset is synchronous and clears all control state; the column store
//  needs no clearing since only rows of the current board are read.
//  A waiting response holds the back end in its scoring step; rows then collect
//  in the queue and req_full rises once it holds four.
//
module n_queens_conflict_scorer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  nqcs_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output nqcs_pkg::rsp_type rsp_data
);
   import nqcs_pkg::*;

   queue_status_type queue_status;
   job_type          queue_in_data;
   job_type          queue_head;
   logic             queue_push;
   logic             queue_pop;

   // Front: number each request within its board and flag overflow rows.
   nqcs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .queue_status (queue_status),
      .queue_push   (queue_push),
      .queue_data   (queue_in_data)
   );

   // Queue: hold classified rows while the back end scans.
   nqcs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in_data),
      .pop       (queue_pop),
      .head      (queue_head),
      .status    (queue_status)
   );

   // Back: store, scan, score, and present the response register.
   nqcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_head   (queue_head),
      .queue_pop    (queue_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule
